// ===== hw/rtl/gelu_pkg.sv =====
// Shared constants, types and the tanh table builder for the GELU activation block.
// Depends on nothing; imported by gelu_tanh_lut, gelu_tanh_activation_top, the checker and the testbench.
`default_nettype none

package gelu_pkg;

    // Sample format: signed Q4.12.
    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 12;
    // Table of tanh over [0, 4] with linear interpolation between entries.
    localparam int TANH_DEPTH = 256;
    localparam int IDX_W      = $clog2(TANH_DEPTH);
    localparam int ROM_AW     = IDX_W + 1;

    // Mode register codes.
    localparam logic MODE_GELU  = 1'b0;
    localparam logic MODE_DERIV = 1'b1;

    // Fixed-point constants, Q28: sqrt(2/pi), 0.044715 and 3 * 0.044715.
    localparam logic [27:0] K_SQRT2PI = 28'd214180506;
    localparam logic [23:0] K_CUBIC   = 24'd12003091;
    localparam logic [25:0] K_CUBIC3  = 26'd36009273;

    // One in Q30 and Q28.
    localparam logic [30:0] Q30_ONE = 31'(64'd1 << 30);
    localparam logic [29:0] Q28_ONE = 30'(64'd1 << 28);

    typedef logic [29:0] t_q30;
    typedef t_q30 t_tanh_rom [TANH_DEPTH + 1];

    // Unsigned 64-bit quotient by restoring long division, used only while the
    // table is built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds tanh(4*i/TANH_DEPTH) in unsigned Q30 at elaboration. exp(-s) comes from a
    // twelve-term Taylor series in Q31 and is raised to the 16th power by four squarings.
    function automatic t_tanh_rom build_tanh_rom();
        t_tanh_rom   rom;
        logic [63:0] s;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] one31;
        for (int i = 0; i <= TANH_DEPTH; i++) begin
            one31 = 64'd1 << 31;
            // The table depth is a power of two, so i*2^31 / (2*TANH_DEPTH) is a shift.
            s     = (64'(i) << 31) >> (IDX_W + 1);
            sum   = one31;
            term  = one31;
            for (int k = 1; k <= 12; k++) begin
                term = udiv64((term * s) >> 31, 64'(k));
                if (k[0]) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            for (int j = 0; j < 4; j++) begin
                sum = (sum * sum) >> 31;
            end
            if (sum > one31) begin
                sum = one31;
            end
            rom[i] = 30'(udiv64((one31 - sum) << 30, one31 + sum));
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gelu_tanh_activation_top.sv =====
// An accepted sample passes the stage registers and then the output register before o_valid.
// Throughput: one sample per cycle unless i_stall holds the pipeline; stages two to eleven each hold a
// multiplier or the table. The whole pipeline holds while a finished result waits under i_stall, so nothing is lost.
// Reset clears the stage valid bits, the output valid and the mode register (GELU value).
// GELU / derivative top level: thirteen pipeline stages with a tanh table unit.
// Depends on gelu_pkg and gelu_tanh_lut.
`default_nettype none

module gelu_tanh_activation_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_mode_we,
    input  wire logic                                i_mode_wdata,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [gelu_pkg::DATA_W-1:0]  i_x_in,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [gelu_pkg::DATA_W-1:0]       o_y_out
);
    import gelu_pkg::*;

    typedef struct packed {
        logic        neg;
        logic        big;
        logic [15:0] amag;
    } t_side;

    localparam logic [15:0] BIG_LIMIT = 16'(4 << FRAC_W);
    localparam logic [16:0] POS_MAX   = 17'((1 << (DATA_W - 1)) - 1);
    localparam logic [16:0] NEG_MAX   = 17'(1 << (DATA_W - 1));
    localparam logic [15:0] ONE_OUT   = 16'(1 << FRAC_W);
    localparam logic [45:0] RND_GELU  = 46'(64'd1 << 30);
    localparam logic [35:0] RND_DERIV = 36'(64'd1 << (30 - FRAC_W));

    logic        w_adv;
    logic        r_mode;
    logic [12:1] r_v;
    logic        r_out_valid;
    logic        r_out_neg;
    logic        r_out_big;

    t_side       r_sd [1:12];
    t_side       n_sd;

    logic [27:0] r_sq;
    logic [33:0] r_a3;
    logic [29:0] r_poly [3:10];
    logic [30:0] r_inner;
    logic [30:0] r_u;
    logic [31:0] r_w [8:11];
    logic [45:0] r_gw;
    logic [30:0] r_sech2;
    logic [30:0] r_m1;
    logic [15:0] r_gmag [9:12];
    logic [30:0] r_m2;
    logic [34:0] r_m4;
    logic [35:0] r_d;
    logic        r_dneg;

    logic [15:0] w_xu;
    logic [27:0] n_sq;
    logic [41:0] w_cube;
    logic [53:0] w_polyprod;
    logic [29:0] n_poly;
    logic [57:0] w_cprod;
    logic [30:0] n_inner;
    logic [58:0] w_uprod;
    logic [30:0] w_t;
    logic [31:0] n_w;
    logic [61:0] w_tt;
    logic [30:0] n_sech2;
    logic [44:0] w_m1prod;
    logic [45:0] w_gsum;
    logic [58:0] w_m2prod;
    logic [60:0] w_m4prod;
    logic [35:0] w_wx;
    logic [35:0] w_m4x;
    logic [35:0] n_d;
    logic        n_dneg;
    logic [35:0] w_dsum;
    logic [16:0] w_mag;
    logic        w_oneg;
    logic [16:0] w_neg_mag;
    logic [15:0] n_y;

    // The pipeline moves as one whenever the output register is free or being taken.
    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_out_valid;

    // Mode register and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_GELU;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_mode_we) begin
                r_mode <= i_mode_wdata;
            end
            if (w_adv) begin
                r_v         <= {r_v[11:1], i_valid};
                r_out_valid <= r_v[12];
            end
        end
    end

    // Stage one: split the sample into sign and magnitude; four or more takes the short path.
    always_comb begin
        w_xu      = i_x_in;
        n_sd.neg  = w_xu[15];
        n_sd.amag = w_xu[15] ? (~w_xu + 16'd1) : w_xu;
        n_sd.big  = (n_sd.amag >= BIG_LIMIT);
    end

    // Polynomial part: |x|^2, |x|^3, the inner argument u and the derivative polynomial.
    always_comb begin
        n_sq       = 28'(r_sd[1].amag[13:0]) * 28'(r_sd[1].amag[13:0]);
        w_cube     = 42'(r_sq) * 42'(r_sd[2].amag[13:0]);
        w_polyprod = 54'(K_CUBIC3) * 54'(r_sq);
        n_poly     = Q28_ONE + w_polyprod[53:24];
        w_cprod    = 58'(K_CUBIC) * 58'(r_a3);
        n_inner    = 31'({r_sd[3].amag[13:0], 16'd0}) + 31'(w_cprod[57:28]);
        w_uprod    = 59'(K_SQRT2PI) * 59'(r_inner);
    end

    gelu_tanh_lut u_tanh (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_u   (r_u),
        .o_t   (w_t)
    );

    // Combination of tanh with the sample: GELU product, sech^2 and the derivative term.
    always_comb begin
        n_w      = r_sd[7].neg ? (32'(Q30_ONE) - 32'(w_t)) : (32'(Q30_ONE) + 32'(w_t));
        w_tt     = 62'(w_t) * 62'(w_t);
        n_sech2  = Q30_ONE - 31'(w_tt[61:30]);
        w_m1prod = 45'(r_sd[8].amag[13:0]) * 45'(r_sech2);
        w_gsum   = r_gw + RND_GELU;
        w_m2prod = 59'(r_m1) * 59'(K_SQRT2PI);
        w_m4prod = 61'(r_m2) * 61'(r_poly[10]);
    end

    // Derivative sum: w plus the term for nonnegative x, the signed difference otherwise.
    always_comb begin
        w_wx  = 36'(r_w[11]);
        w_m4x = 36'(r_m4);
        if (!r_sd[11].neg) begin
            n_d    = w_wx + w_m4x;
            n_dneg = 1'b0;
        end else if (w_m4x > w_wx) begin
            n_d    = w_m4x - w_wx;
            n_dneg = 1'b1;
        end else begin
            n_d    = w_wx - w_m4x;
            n_dneg = 1'b0;
        end
    end

    // Final stage: pick the result for the mode, round the derivative and saturate.
    always_comb begin
        w_dsum = r_d + RND_DERIV;
        if (r_sd[12].big) begin
            w_oneg = 1'b0;
            if (r_sd[12].neg) begin
                w_mag = 17'd0;
            end else if (r_mode == MODE_DERIV) begin
                w_mag = 17'(ONE_OUT);
            end else begin
                w_mag = 17'(r_sd[12].amag);
            end
        end else if (r_mode == MODE_GELU) begin
            w_mag  = 17'(r_gmag[12]);
            w_oneg = r_sd[12].neg;
        end else begin
            w_mag  = w_dsum[35:19];
            w_oneg = r_dneg;
        end
        w_neg_mag = (w_mag > NEG_MAX) ? NEG_MAX : w_mag;
        if (w_oneg && (w_mag != 17'd0)) begin
            n_y = 16'(~w_neg_mag + 17'd1);
        end else if (w_mag > POS_MAX) begin
            n_y = POS_MAX[15:0];
        end else begin
            n_y = w_mag[15:0];
        end
    end

    // Datapath registers; they advance with the valid bits.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[1] <= n_sd;
            for (int s = 2; s <= 12; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
            r_sq      <= n_sq;
            r_a3      <= w_cube[41:8];
            r_poly[3] <= n_poly;
            for (int s = 4; s <= 10; s++) begin
                r_poly[s] <= r_poly[s-1];
            end
            r_inner   <= n_inner;
            r_u       <= w_uprod[58:28];
            r_w[8]    <= n_w;
            for (int s = 9; s <= 11; s++) begin
                r_w[s] <= r_w[s-1];
            end
            r_gw      <= 46'(r_sd[7].amag[13:0]) * 46'(n_w);
            r_sech2   <= n_sech2;
            r_m1      <= w_m1prod[44:14];
            r_gmag[9] <= 16'(w_gsum[45:31]);
            for (int s = 10; s <= 12; s++) begin
                r_gmag[s] <= r_gmag[s-1];
            end
            r_m2      <= w_m2prod[58:28];
            r_m4      <= {w_m4prod[60:28], 2'b00};
            r_d       <= n_d;
            r_dneg    <= n_dneg;
            o_y_out   <= n_y;
            r_out_neg <= r_sd[12].neg;
            r_out_big <= r_sd[12].big;
        end
    end

    // A held pipeline keeps every stage's valid bit in place.
    a_hold_stages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_v) && $stable(r_out_valid))
        else $error("pipeline valid bits moved while the output was stalled");

    // Interpolated tanh never exceeds one.
    a_tanh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[7] |-> (w_t <= Q30_ONE))
        else $error("tanh value above one");

    // A nonnegative sample never gives a negative result in either mode.
    a_pos_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_neg) |-> !o_y_out[DATA_W-1])
        else $error("negative result for a nonnegative sample");

    // Large negative samples give zero in both modes.
    a_big_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_neg && r_out_big) |-> (o_y_out == '0))
        else $error("nonzero result for a large negative sample");

endmodule

`default_nettype wire

// ===== hw/rtl/gelu_tanh_lut.sv =====
// Two-stage tanh unit: table read of both neighbors, then linear interpolation.
// Depends on gelu_pkg for the table builder and Q30 constants.
`default_nettype none

module gelu_tanh_lut (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [30:0] i_u,
    output logic      [30:0] o_t
);
    import gelu_pkg::*;

    localparam t_tanh_rom TANH_ROM = build_tanh_rom();

    logic [IDX_W-1:0]  w_idx;
    logic [ROM_AW-1:0] w_idx_lo;
    logic [ROM_AW-1:0] w_idx_hi;

    logic              r_sat;
    t_q30              r_lo;
    t_q30              r_hi;
    logic [21:0]       r_frac;

    logic              w_up;
    t_q30              w_diff;
    logic [51:0]       w_prod;
    t_q30              w_step;
    t_q30              w_interp;
    logic [30:0]       n_t;
    logic [30:0]       r_t;

    // The argument is nonnegative Q28; the table spacing is 4/TANH_DEPTH.
    assign w_idx    = i_u[29:22];
    assign w_idx_lo = {1'b0, w_idx};
    assign w_idx_hi = {1'b0, w_idx} + ROM_AW'(1);

    // Stage one: fetch both neighbors and keep the fraction between them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat  <= i_u[30];
            r_lo   <= TANH_ROM[w_idx_lo];
            r_hi   <= TANH_ROM[w_idx_hi];
            r_frac <= i_u[21:0];
        end
    end

    // Stage two: interpolate in either direction; beyond four, tanh is one.
    always_comb begin
        w_up     = (r_hi >= r_lo);
        w_diff   = w_up ? (r_hi - r_lo) : (r_lo - r_hi);
        w_prod   = 52'(w_diff) * 52'(r_frac);
        w_step   = w_prod[51:22];
        w_interp = w_up ? (r_lo + w_step) : (r_lo - w_step);
        n_t      = r_sat ? Q30_ONE : {1'b0, w_interp};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

`default_nettype wire

// ===== verif/gelu_tanh_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the GELU activation block: watches both channels and the mode port,
// predicts each Q4.12 result and compares it in order. Depends on gelu_pkg only.
module gelu_tanh_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_mode_we,
    input  logic                        i_mode_wdata,
    input  logic                        i_x_valid,
    input  logic                        i_x_stall,
    input  logic [gelu_pkg::DATA_W-1:0] i_x,
    input  logic                        i_y_valid,
    input  logic                        i_y_stall,
    input  logic [gelu_pkg::DATA_W-1:0] i_y,
    output int                          o_mismatches,
    output int                          o_outstanding,
    output int                          o_compared
);
    import gelu_pkg::*;

    localparam int DW          = DATA_W;
    localparam int MAX_REPORTS = 10;
    localparam logic [63:0] ONE30 = 64'd1 << 30;
    localparam logic [63:0] ONE28 = 64'd1 << 28;

    typedef struct packed {
        logic [DW-1:0] x;
        logic          mode;
        logic [DW-1:0] y;
    } t_gelu_expect;

    t_gelu_expect awaited_y [$];
    logic [29:0]  tanh_knots [0:TANH_DEPTH];
    logic         mode_q;

    // Knot i holds tanh(4*i/TANH_DEPTH) in Q30, computed as (1 - e) / (1 + e) with
    // e = exp(-2*v): a twelve-term series for exp(-v/8) in Q31, squared four times.
    initial begin : build_knots
        logic [63:0] s;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] one31;
        one31 = 64'd1 << 31;
        for (int i = 0; i <= TANH_DEPTH; i++) begin
            s    = (64'(i) << 31) / 64'(2 * TANH_DEPTH);
            acc  = one31;
            term = one31;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * s) >> 31) / 64'(k);
                if (k % 2 == 1) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
            end
            repeat (4) acc = (acc * acc) >> 31;
            if (acc > one31) begin
                acc = one31;
            end
            tanh_knots[i] = 30'(((one31 - acc) << 30) / (one31 + acc));
        end
    end

    // Round to nearest, ties away from zero, on a magnitude.
    function automatic logic [63:0] round_mag(input logic [63:0] v, input int sh);
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Expected Q4.12 output for one sample. The datapath runs on |x| in Q28 and puts
    // the sign back at the end, since u and tanh are odd.
    function automatic logic [DW-1:0] predict_gelu(input logic [DW-1:0] raw,
                                                   input logic mode_bit);
        logic          neg;
        logic          yneg;
        logic [DW-1:0] raw_neg;
        int            knot_idx;
        logic [63:0]   amag, a, a2, a3, u, p, frac, lo, hi, t, w;
        logic [63:0]   sech2, poly, m1, m2, m4, d, mag, lim;
        neg     = raw[DW-1];
        raw_neg = -raw;
        amag    = neg ? 64'(raw_neg) : 64'(raw);
        yneg    = 1'b0;
        if (amag >= (64'd4 << FRAC_W)) begin
            // Past |x| = 4 tanh is saturated: the value is relu(x) and the slope a step.
            if (neg) begin
                mag = 64'd0;
            end else if (mode_bit == MODE_DERIV) begin
                mag = 64'd1 << FRAC_W;
            end else begin
                mag = amag;
            end
        end else begin
            a  = amag << (28 - FRAC_W);
            a2 = (a * a) >> 28;
            a3 = (a2 * a) >> 28;
            u  = (64'(K_SQRT2PI) * (a + ((64'(K_CUBIC) * a3) >> 28))) >> 28;
            // Linear interpolation between neighboring knots below u = 4.
            if (u >= (64'd4 << 28)) begin
                t = ONE30;
            end else begin
                p        = u * 64'(TANH_DEPTH);
                knot_idx = int'(p >> 30);
                frac     = p & (ONE30 - 64'd1);
                lo       = 64'(tanh_knots[knot_idx]);
                hi       = 64'(tanh_knots[knot_idx + 1]);
                if (hi >= lo) begin
                    t = lo + (((hi - lo) * frac) >> 30);
                end else begin
                    t = lo - (((lo - hi) * frac) >> 30);
                end
            end
            w = neg ? ONE30 - t : ONE30 + t;
            if (mode_bit == MODE_GELU) begin
                mag  = round_mag(a * w, 59 - FRAC_W);
                yneg = neg;
            end else begin
                // Slope: 0.5*(1 + tanh) + 0.5*x*sech^2*k*(1 + 3c*x^2), kept as twice y.
                sech2 = ONE30 - ((t * t) >> 30);
                poly  = ONE28 + ((64'(K_CUBIC3) * a2) >> 28);
                m1    = (a * sech2) >> 30;
                m2    = (m1 * 64'(K_SQRT2PI)) >> 28;
                m4    = ((m2 * poly) >> 28) << 2;
                if (!neg) begin
                    d = w + m4;
                end else if (m4 > w) begin
                    d    = m4 - w;
                    yneg = 1'b1;
                end else begin
                    d = w - m4;
                end
                mag = round_mag(d, 31 - FRAC_W);
            end
        end
        // Clamp to the signed output range.
        if (yneg && mag != 64'd0) begin
            lim = 64'd1 << (DW - 1);
            if (mag > lim) begin
                mag = lim;
            end
            return DW'(64'd0 - mag);
        end
        lim = (64'd1 << (DW - 1)) - 64'd1;
        if (mag > lim) begin
            mag = lim;
        end
        return DW'(mag);
    endfunction

    // Track the mode, queue a prediction per input transfer, check each output transfer.
    always @(posedge i_clk) begin
        t_gelu_expect entry;
        t_gelu_expect head;
        if (!i_rst_n) begin
            mode_q <= MODE_GELU;
        end else begin
            if (i_mode_we) begin
                mode_q <= i_mode_wdata;
            end
            if (i_x_valid && !i_x_stall) begin
                entry.x    = i_x;
                entry.mode = mode_q;
                entry.y    = predict_gelu(i_x, mode_q);
                awaited_y.push_back(entry);
            end
            if (i_y_valid && !i_y_stall) begin
                if (awaited_y.size() == 0) begin
                    if (o_mismatches < MAX_REPORTS) begin
                        $display("%0t: unexpected result y=%0d with nothing pending",
                                 $time, $signed(i_y));
                    end
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    head = awaited_y.pop_front();
                    o_compared <= o_compared + 1;
                    if (i_y !== head.y) begin
                        if (o_mismatches < MAX_REPORTS) begin
                            $display("%0t: y_out wrong for mode %0d x=%0d: expected %0d got %0d",
                                     $time, head.mode, $signed(head.x), $signed(head.y),
                                     $signed(i_y));
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
        o_outstanding <= awaited_y.size();
    end

endmodule

// ===== verif/gelu_tanh_activation_top_tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for gelu_tanh_activation_top: clock, reset, mode writes and samples.
// Depends on gelu_pkg, gelu_tanh_activation_top and gelu_tanh_checker.
module gelu_tanh_activation_top_tb;
    import gelu_pkg::*;

    localparam int DW          = DATA_W;
    localparam int PIPE_LAT    = 13;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 125;
    localparam int NUM_PHASES  = 6;
    localparam int BOUND4      = 4 << FRAC_W;

    logic          i_clk;
    logic          rst_n      = 1'b0;
    logic          mode_we    = 1'b0;
    logic          mode_wdata = 1'b0;
    logic          x_valid    = 1'b0;
    logic [DW-1:0] x_data     = '0;
    logic          y_stall    = 1'b0;
    logic          no_idle    = 1'b0;
    logic          x_stall;
    logic          y_valid;
    logic [DW-1:0] y_data;

    int stall_left   = 0;
    int rx_wait      = 0;
    int cycle_count  = 0;
    int samples_sent = 0;
    int mode_writes  = 0;
    int mismatches;
    int outstanding;
    int compared;

    logic [DW-1:0] directed_x [0:11];
    logic          phase_mode [0:NUM_PHASES-1];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    gelu_tanh_activation_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_mode_we    (mode_we),
        .i_mode_wdata (mode_wdata),
        .i_valid      (x_valid),
        .o_stall      (x_stall),
        .i_x_in       (x_data),
        .o_valid      (y_valid),
        .i_stall      (y_stall),
        .o_y_out      (y_data)
    );

    gelu_tanh_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_mode_we     (mode_we),
        .i_mode_wdata  (mode_wdata),
        .i_x_valid     (x_valid),
        .i_x_stall     (x_stall),
        .i_x           (x_data),
        .i_y_valid     (y_valid),
        .i_y_stall     (y_stall),
        .i_y           (y_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     outstanding);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output side: after each transfer, and now and then when idle, may raise y_stall; never while no_idle is set.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            y_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            y_stall    <= 1'b0;
        end else if ((y_valid && !y_stall) || $urandom_range(0, 3) == 0) begin
            rx_wait    = no_idle ? 0 : $urandom_range(0, 7);
            stall_left <= rx_wait;
            y_stall    <= (rx_wait != 0);
        end
    end

    // One input transfer after a random gap; valid stays high when the gap is zero.
    task automatic send_sample(input logic [DW-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            x_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        x_valid <= 1'b1;
        x_data  <= v;
        do @(posedge i_clk); while (x_stall);
        samples_sent++;
    endtask

    // Wait until every predicted result has been taken off the output.
    task automatic drain();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Mode writes happen only with the pipeline empty.
    task automatic write_mode(input logic m);
        x_valid <= 1'b0;
        drain();
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(posedge i_clk);
        mode_we <= 1'b0;
        mode_writes++;
    endtask

    // Mostly the interpolated region inside |x| < 4, plus the 4.0 boundary,
    // tiny values, full-range noise and both rails.
    function automatic logic [DW-1:0] pick_sample();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = DW'($urandom_range(0, 2 * BOUND4 - 1)) - DW'(BOUND4);
            5, 6: v = DW'($urandom);
            7: begin
                v = DW'(BOUND4 - 8 + $urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            8: v = DW'($urandom_range(0, 255)) - DW'(128);
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    v = DW'((1 << (DW - 1)) - 1 - $urandom_range(0, 3));
                end else begin
                    v = DW'((1 << (DW - 1)) + $urandom_range(0, 3));
                end
            end
        endcase
        return v;
    endfunction

    // Main sequence: reset, directed edges in both modes, then random phases.
    initial begin
        directed_x = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h3FFF,
                       16'h4000, 16'hC001, 16'hC000, 16'h1000, 16'hF000, 16'hE890};
        phase_mode = '{MODE_GELU, MODE_DERIV, MODE_DERIV, MODE_GELU, MODE_DERIV, MODE_GELU};
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero, one LSB, the rails, both sides of |x| = 4, +-1.0 and a negative slope.
        foreach (directed_x[i]) begin
            send_sample(directed_x[i]);
        end
        write_mode(MODE_DERIV);
        foreach (directed_x[i]) begin
            send_sample(directed_x[i]);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_mode(phase_mode[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    no_idle <= ($urandom_range(0, 3) == 0);
                end
                send_sample(pick_sample());
            end
        end

        x_valid <= 1'b0;
        drain();
        repeat (2 * PIPE_LAT) @(posedge i_clk);

        $display("Sent %0d samples (%0d directed) over %0d mode writes; %0d results compared.",
                 samples_sent, 2 * 12, mode_writes, compared);
        $display("Mix: interior of |x| < 4, the 4.0 boundary, tiny values, noise and rails.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== gelu_tanh_activation_top.f =====
hw/rtl/gelu_pkg.sv
hw/rtl/gelu_tanh_lut.sv
hw/rtl/gelu_tanh_activation_top.sv
verif/gelu_tanh_checker.sv
verif/gelu_tanh_activation_top_tb.sv
